// ----- src/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, register indexes, reset values and controller states for
// the scalar kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 13;
  localparam int COV_BITS    = 24;

  localparam int GAIN_BITS = FRAC_BITS + 1;
  localparam int EST_BITS  = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int DIFF_BITS = EST_BITS + 1;
  localparam int ACC_BITS  = DIFF_BITS + 1;
  localparam int DEN_BITS  = COV_BITS + 1;
  localparam int CNT_BITS  = $clog2(GAIN_BITS);

  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROCESS_NOISE      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_COVARIANCE = 2'd2;

  localparam logic [COV_BITS-1:0] RST_PROCESS_NOISE      = COV_BITS'(6554);
  localparam logic [COV_BITS-1:0] RST_MEASUREMENT_NOISE  = COV_BITS'(655360);
  localparam logic [COV_BITS-1:0] RST_INITIAL_COVARIANCE = COV_BITS'(131072);

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- src/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional kalman filter: estimate and error covariance in fixed
// point, gain by a bit-serial restoring divider, updates by bit-serial
// shift-and-add multipliers.
// A sample taken in the idle state passes through a setup state, the
// divider state, the multiplier state and a result state before out_valid
// rises. The divider and multiplier are serial, one gain bit per cycle
// each; a new sample is taken only once the result state returns to idle,
// and the result state waits while an earlier result beat stalls.
// Reset: synchronous, clears the estimate, loads covariance 2.0 and the
// register defaults; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter import skf_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [COV_BITS-1:0]           cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          restart,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic signed [SAMPLE_BITS-1:0] estimate,
  output      logic [GAIN_BITS-1:0]          gain
);

  state_t state, state_next;

  logic [COV_BITS-1:0] process_noise;
  logic [COV_BITS-1:0] measurement_noise;
  logic [COV_BITS-1:0] initial_covariance;

  logic signed [EST_BITS-1:0] est;
  logic [COV_BITS-1:0]        cov;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic                          rs;

  logic [COV_BITS-1:0]  p;
  logic [DEN_BITS-1:0]  den;
  logic                 den_zero;
  logic [DEN_BITS-1:0]  rem;
  logic [GAIN_BITS-1:0] nbits;
  logic [GAIN_BITS-1:0] quo;
  logic [CNT_BITS-1:0]  cnt;

  logic [GAIN_BITS-1:0]        gsr;
  logic [GAIN_BITS-1:0]        hsr;
  logic [GAIN_BITS-1:0]        gain_hold;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [ACC_BITS-1:0]  eacc;
  logic [DEN_BITS-1:0]         cacc;

  logic in_fire, out_fire, cfg_fire;
  logic do_prep, do_div, do_mul, do_done;
  logic last;

  // setup arithmetic
  logic [COV_BITS-1:0]        p_base;
  logic signed [EST_BITS-1:0] est_base;
  logic [DEN_BITS-1:0]        p_sum;
  logic [COV_BITS-1:0]        p_sat;
  logic [DEN_BITS-1:0]        den_calc;
  logic signed [DIFF_BITS-1:0] smp_q;

  // divider step
  logic [DEN_BITS:0]      trial;
  logic                   qbit;
  logic [GAIN_BITS-1:0]   quo_next;
  logic [GAIN_BITS-1:0]   g_final;

  // multiplier step
  logic signed [ACC_BITS-1:0] eacc_sum;
  logic [DEN_BITS-1:0]        cacc_sum;

  // output formatting
  logic [EST_BITS-FRAC_BITS-1:0] trunc;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign last     = (cnt == CNT_BITS'(FRAC_BITS));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV:  if (last) state_next = ST_MUL;
      ST_MUL:  if (last) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b1;
    do_prep   = 1'b0;
    do_div    = 1'b0;
    do_mul    = 1'b0;
    do_done   = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_PREP: do_prep  = 1'b1;
      ST_DIV:  do_div   = 1'b1;
      ST_MUL:  do_mul   = 1'b1;
      ST_DONE: do_done  = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise      <= RST_PROCESS_NOISE;
      measurement_noise  <= RST_MEASUREMENT_NOISE;
      initial_covariance <= RST_INITIAL_COVARIANCE;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_PROCESS_NOISE:      process_noise      <= cfg_data;
        REG_MEASUREMENT_NOISE:  measurement_noise  <= cfg_data;
        REG_INITIAL_COVARIANCE: initial_covariance <= cfg_data;
        default:                process_noise      <= process_noise;
      endcase
    end
  end

  // setup: restart, saturating predict, denominator, innovation
  always_comb begin
    p_base   = rs ? initial_covariance : cov;
    est_base = rs ? '0 : est;
    p_sum    = {1'b0, p_base} + {1'b0, process_noise};
    p_sat    = p_sum[COV_BITS] ? '1 : p_sum[COV_BITS-1:0];
    den_calc = {1'b0, p_sat} + {1'b0, measurement_noise};
    smp_q    = DIFF_BITS'(smp) <<< FRAC_BITS;
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    trial    = {rem, nbits[GAIN_BITS-1]};
    qbit     = (trial >= {1'b0, den});
    quo_next = {quo[GAIN_BITS-2:0], qbit};
    g_final  = den_zero ? '0 : quo_next;
  end

  // shift-and-add multipliers, lsb of the multiplier first
  always_comb begin
    eacc_sum = eacc + (gsr[0] ? ACC_BITS'(diff) : '0);
    cacc_sum = cacc + (hsr[0] ? {1'b0, p} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      cov <= RST_INITIAL_COVARIANCE;
    end else begin
      if (in_fire) begin
        smp <= sample;
        rs  <= restart;
      end
      if (do_prep) begin
        p        <= p_sat;
        den      <= den_calc;
        den_zero <= (den_calc == '0);
        rem      <= DEN_BITS'(p_sat >> 1);
        nbits    <= {p_sat[0], {FRAC_BITS{1'b0}}};
        quo      <= '0;
        cnt      <= '0;
        est      <= est_base;
        diff     <= smp_q - DIFF_BITS'(est_base);
      end
      if (do_div) begin
        if (qbit) rem <= DEN_BITS'(trial - {1'b0, den});
        else      rem <= trial[DEN_BITS-1:0];
        nbits <= nbits << 1;
        quo   <= quo_next;
        if (last) begin
          cnt       <= '0;
          gain_hold <= g_final;
          gsr       <= g_final;
          hsr       <= GAIN_ONE - g_final;
          eacc      <= '0;
          cacc      <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (do_mul) begin
        gsr <= gsr >> 1;
        hsr <= hsr >> 1;
        cnt <= cnt + 1'b1;
        if (last) begin
          est <= EST_BITS'(ACC_BITS'(est) + eacc_sum);
          cov <= cacc_sum[COV_BITS-1:0];
        end else begin
          eacc <= eacc_sum >>> 1;
          cacc <= cacc_sum >> 1;
        end
      end
    end
  end

  // truncate toward zero
  assign trunc = est[EST_BITS-1:FRAC_BITS]
               + (EST_BITS-FRAC_BITS)'(est[EST_BITS-1] && (|est[FRAC_BITS-1:0]));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_done) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
    if (do_done) begin
      estimate <= trunc[SAMPLE_BITS-1:0];
      gain     <= gain_hold;
    end
  end

endmodule

`default_nettype wire

// ----- src/skf_checker.sv -----
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks on the scalar kalman filter, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_checker import skf_pkg::*; (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [SAMPLE_BITS-1:0] estimate,
  input wire logic [GAIN_BITS-1:0]          gain
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(estimate) && $stable(gain))
    else $error("result beat changed while stalled");

  // gain never above one
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain <= GAIN_ONE)
    else $error("gain above one");

  // one sample at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken while busy");

  // no result right after an input beat
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result too early");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .estimate  (estimate),
  .gain      (gain)
);

`default_nettype wire

// ----- tb/tb_scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scalar kalman filter. Samples go out on a
// valid/ready channel in random bursts. The filtered estimate and gain come
// back under a stall pattern that changes over time. Each output beat is
// compared with an in-bench fixed-point model of the filter that keeps its
// own estimate, covariance and register copies. Registers are reprogrammed
// between phases while the filter is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import skf_pkg::*;

  localparam longint COV_MAX       = (longint'(1) << COV_BITS) - 1;
  localparam longint ONE_Q         = longint'(1) << FRAC_BITS;
  localparam int     RANDOM_BEATS  = 1500;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     CYCLE_LIMIT   = 1000000;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          restart;
  } sample_beat_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] estimate;
    logic [GAIN_BITS-1:0]          gain;
  } filter_out_t;

  typedef struct {
    logic [CFG_IDX_BITS-1:0] idx;
    logic [COV_BITS-1:0]     data;
  } reg_write_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
  logic [COV_BITS-1:0]           cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample    = '0;
  logic                          restart   = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] estimate;
  logic [GAIN_BITS-1:0]          gain;

  scalar_kalman_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .estimate  (estimate),
    .gain      (gain)
  );

  always #1 clk = ~clk;

  // filter model state and register copies
  longint est_q16   = 0;
  longint cov_q16   = longint'(RST_INITIAL_COVARIANCE);
  longint q_noise   = longint'(RST_PROCESS_NOISE);
  longint r_noise   = longint'(RST_MEASUREMENT_NOISE);
  longint p_initial = longint'(RST_INITIAL_COVARIANCE);

  sample_beat_t sample_queue[$];
  filter_out_t  expected_estimates[$];
  reg_write_t   reg_writes[$];

  sample_beat_t drv_beat;
  filter_out_t  exp_out;
  int unsigned  burst_left   = 1;
  int unsigned  gap_left     = 0;
  int unsigned  rx_left      = 0;
  rx_mode_t     rx_mode      = RX_OPEN;
  logic [15:0]  rx_pattern   = 16'h00ff;
  int unsigned  cycle_count  = 0;
  int unsigned  mismatches   = 0;
  int unsigned  beats_sent   = 0;
  int unsigned  beats_seen   = 0;
  int unsigned  restarts     = 0;
  int unsigned  reg_beats    = 0;
  int unsigned  phases       = 0;
  int           random_beats = 0;
  int           base_level;
  int           level;
  int           phase_len;
  logic [COV_BITS-1:0] r_pick;

  function automatic void kalman_update(input logic signed [SAMPLE_BITS-1:0] smp,
                                        input logic rs);
    longint      p;
    longint      den;
    longint      g;
    longint      diff;
    longint      trunc;
    filter_out_t res;
    if (rs) begin
      cov_q16 = p_initial;
      est_q16 = 0;
    end
    p = cov_q16 + q_noise;
    if (p > COV_MAX) p = COV_MAX;
    den = p + r_noise;
    g = 0;
    if (den != 0) begin
      g = (p << FRAC_BITS) / den;
      diff = (longint'(smp) <<< FRAC_BITS) - est_q16;
      est_q16 = est_q16 + g * (diff >>> FRAC_BITS) + ((g * (diff & (ONE_Q - 1))) >>> FRAC_BITS);
      p = (p * (ONE_Q - g)) >>> FRAC_BITS;
    end
    cov_q16 = p;
    trunc = (est_q16 >= 0) ? (est_q16 >>> FRAC_BITS) : -((-est_q16) >>> FRAC_BITS);
    res.estimate = trunc[SAMPLE_BITS-1:0];
    res.gain     = g[GAIN_BITS-1:0];
    expected_estimates.push_back(res);
  endfunction

  function automatic logic [COV_BITS-1:0] pick_setting(input logic [COV_BITS-1:0] lowest);
    case ($urandom_range(0, 5))
      0:       return lowest;
      1:       return COV_MAX[COV_BITS-1:0];
      2:       return COV_BITS'($urandom);
      default: return COV_BITS'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  task automatic add_sample(input int v, input logic rs);
    sample_beat_t b;
    b.value   = v[SAMPLE_BITS-1:0];
    b.restart = rs;
    sample_queue.push_back(b);
  endtask

  // call at a rising edge, filter idle
  task automatic set_filter(input logic [COV_BITS-1:0] q, input logic [COV_BITS-1:0] r,
                            input logic [COV_BITS-1:0] p0);
    reg_write_t w;
    reg_writes.push_back('{REG_PROCESS_NOISE, q});
    reg_writes.push_back('{REG_MEASUREMENT_NOISE, r});
    reg_writes.push_back('{REG_INITIAL_COVARIANCE, p0});
    if ($urandom_range(0, 3) == 0) reg_writes.push_back('{REG_UNUSED, COV_BITS'($urandom)});
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      reg_beats++;
      case (w.idx)
        REG_PROCESS_NOISE:      q_noise   = longint'(w.data);
        REG_MEASUREMENT_NOISE:  r_noise   = longint'(w.data);
        REG_INITIAL_COVARIANCE: p_initial = longint'(w.data);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    phases++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_estimates.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        kalman_update(sample, restart);
        beats_sent++;
        if (restart) restarts++;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        drv_beat = sample_queue.pop_front();
        in_valid <= 1'b1;
        sample   <= drv_beat.value;
        restart  <= drv_beat.restart;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode    <= rx_mode_t'($urandom_range(0, 3));
        rx_left    <= $urandom_range(20, 300);
        rx_pattern <= 16'($urandom) | 16'h0001;
      end else begin
        rx_left    <= rx_left - 1;
        rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:   out_ready <= rx_pattern[0];
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (expected_estimates.size() == 0) begin
        $error("unexpected result beat: estimate %0d gain %0d", estimate, gain);
        mismatches++;
      end else begin
        exp_out = expected_estimates.pop_front();
        if (estimate !== exp_out.estimate) begin
          $error("estimate mismatch: expected %0d, got %0d", exp_out.estimate, estimate);
          mismatches++;
        end
        if (gain !== exp_out.gain) begin
          $error("gain mismatch: expected %0d, got %0d", exp_out.gain, gain);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_estimates.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, sample extremes and alternating bit patterns
    add_sample(0, 1'b1);
    add_sample(4095, 1'b0);
    add_sample(4095, 1'b0);
    add_sample(-4096, 1'b0);
    add_sample(-4096, 1'b1);
    add_sample(-1, 1'b0);
    add_sample(1, 1'b0);
    add_sample(2730, 1'b0);
    add_sample(-2731, 1'b0);
    drain();

    // zero measurement noise: unity gain, estimate jumps to the sample
    set_filter(COV_BITS'(6554), '0, COV_BITS'(131072));
    add_sample(1234, 1'b1);
    add_sample(-3000, 1'b0);
    add_sample(4095, 1'b0);
    drain();

    // zero denominator: gain 0, state held
    set_filter('0, '0, '0);
    add_sample(100, 1'b1);
    add_sample(-4096, 1'b0);
    add_sample(4095, 1'b0);
    drain();

    // all registers at max, covariance saturates
    set_filter('1, '1, '1);
    add_sample(4095, 1'b1);
    add_sample(-4096, 1'b0);
    add_sample(-4096, 1'b0);
    add_sample(0, 1'b0);
    drain();

    // zero gain, then large covariance against minimum noise
    set_filter('0, '1, '0);
    add_sample(4095, 1'b1);
    add_sample(-4096, 1'b0);
    drain();
    set_filter('1, COV_BITS'(1), '1);
    add_sample(-4096, 1'b1);
    add_sample(4095, 1'b0);
    drain();

    while (random_beats < RANDOM_BEATS) begin
      r_pick = pick_setting(COV_BITS'(1));
      if (r_pick == '0) r_pick = COV_BITS'(1);
      set_filter(pick_setting('0), r_pick, pick_setting('0));
      base_level = int'($urandom_range(0, 8191)) - 4096;
      phase_len = $urandom_range(120, 220);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 49) == 0) base_level = int'($urandom_range(0, 8191)) - 4096;
        case ($urandom_range(0, 9))
          0:       level = ($urandom_range(0, 1) != 0) ? 4095 : -4096;
          1, 2, 3: level = int'($urandom_range(0, 8191)) - 4096;
          default: level = base_level + int'($urandom_range(0, 64)) - 32;
        endcase
        if (level > 4095) level = 4095;
        if (level < -4096) level = -4096;
        add_sample(level, (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0));
      end
      random_beats += phase_len;
      drain();
    end

    $display("covered %0d sample beats (%0d restarts) over %0d register phases",
             beats_sent, restarts, phases);
    $display("%0d register beats, %0d result beats checked, %0d mismatches",
             reg_beats, beats_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
